// File: rtl/pac_pkg.sv
// Shared constants and types for the polygon area and convexity block.
package pac_pkg;

   // Fixed field widths of the vertex and result items, and the internal sum width
   localparam int IN_W = 16;
   localparam int AREA_W = 34;
   localparam int SUM_W = 48;

   // Default coordinate width actually used from each input field
   localparam int COORD_WIDTH_DEFAULT = 16;

   // Saturating count of vertices seen in the current polygon
   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE = 2'd1;
   localparam logic [1:0] CNT_MANY = 2'd2;

   // Control that travels with a vertex down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic has_prev;   // an edge from the previous vertex exists
      logic has_turn;   // at least two vertices came before this one
   } pac_ctrl_type;

endpackage

// File: rtl/pac_if.sv
// Handshake channels for vertex items and result items.
interface pac_req_if;
   import pac_pkg::*;
   logic valid;
   logic ready;
   logic signed [IN_W-1:0] coord_x;
   logic signed [IN_W-1:0] coord_y;
   logic last_vertex;

   modport source (output valid, output coord_x, output coord_y, output last_vertex,
                   input ready);
   modport sink (input valid, input coord_x, input coord_y, input last_vertex,
                 output ready);
endinterface

interface pac_rsp_if;
   import pac_pkg::*;
   logic valid;
   logic ready;
   logic [AREA_W-1:0] double_area;
   logic is_concave;

   modport source (output valid, output double_area, output is_concave, input ready);
   modport sink (input valid, input double_area, input is_concave, output ready);
endinterface

// File: rtl/polygon_area_convexity.sv
// Top level of the streaming polygon area and convexity unit.
//
// Vertices come in on req_ch, one item per vertex, with last_vertex set on the
// vertex that closes the polygon. Only that closing vertex makes a result on
// rsp_ch: twice the enclosed area (absolute, clipped to 34 bits) and a flag that
// is set when turns of both signs were found. Polygons of one or two vertices
// give area zero and not concave.
// One vertex is taken per clock cycle except while the pipeline holds. The result
// becomes valid after the closing vertex has passed the input, product, combine,
// accumulate and result registers in a row.
// When the receiver stalls, vertices keep flowing; req_ch.ready drops only
// while one result sits in the result register and a second one waits
// behind it, and the whole pipeline then holds in place.
// Reset clears the vertex history, running sum, turn flags and all valid bits;
// the block is ready for vertices as soon as reset is released.
module polygon_area_convexity
   import pac_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   pac_req_if.sink   req_ch,
   pac_rsp_if.source rsp_ch
);

   logic adv, acc;
   logic signed [COORD_WIDTH-1:0] x, y;
   pac_ctrl_type a_ctrl, c_ctrl;
   logic signed [COORD_WIDTH-1:0] a_x, a_y, a_px, a_py, a_ox, a_oy;
   logic signed [COORD_WIDTH-1:0] a_fx, a_fy, a_sx, a_sy;
   logic signed [SUM_W-1:0] c_edge_sum;
   logic c_pos, c_neg;

   // Low COORD_WIDTH bits of each coordinate, sign extended
   generate
      if (COORD_WIDTH <= IN_W) begin : g_narrow
         assign x = req_ch.coord_x[COORD_WIDTH-1:0];
         assign y = req_ch.coord_y[COORD_WIDTH-1:0];
      end else begin : g_wide
         assign x = COORD_WIDTH'(req_ch.coord_x);
         assign y = COORD_WIDTH'(req_ch.coord_y);
      end
   endgenerate

   assign req_ch.ready = adv;
   assign acc = req_ch.valid && adv;

   pac_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .acc    (acc),
      .x      (x),
      .y      (y),
      .last   (req_ch.last_vertex),
      .a_ctrl (a_ctrl),
      .a_x    (a_x),
      .a_y    (a_y),
      .a_px   (a_px),
      .a_py   (a_py),
      .a_ox   (a_ox),
      .a_oy   (a_oy),
      .a_fx   (a_fx),
      .a_fy   (a_fy),
      .a_sx   (a_sx),
      .a_sy   (a_sy)
   );

   pac_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .a_ctrl     (a_ctrl),
      .a_x        (a_x),
      .a_y        (a_y),
      .a_px       (a_px),
      .a_py       (a_py),
      .a_ox       (a_ox),
      .a_oy       (a_oy),
      .a_fx       (a_fx),
      .a_fy       (a_fy),
      .a_sx       (a_sx),
      .a_sy       (a_sy),
      .c_ctrl     (c_ctrl),
      .c_edge_sum (c_edge_sum),
      .c_pos      (c_pos),
      .c_neg      (c_neg)
   );

   pac_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .c_ctrl          (c_ctrl),
      .c_edge_sum      (c_edge_sum),
      .c_pos           (c_pos),
      .c_neg           (c_neg),
      .rsp_ready       (rsp_ch.ready),
      .adv             (adv),
      .rsp_valid       (rsp_ch.valid),
      .rsp_double_area (rsp_ch.double_area),
      .rsp_is_concave  (rsp_ch.is_concave)
   );

endmodule

// File: rtl/pac_front.sv
// Vertex history (first, second, previous, older) and the input stage register.
module pac_front
   import pac_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          acc,
   input  logic signed [COORD_WIDTH-1:0] x,
   input  logic signed [COORD_WIDTH-1:0] y,
   input  logic                          last,
   output pac_ctrl_type                  a_ctrl,
   output logic signed [COORD_WIDTH-1:0] a_x,
   output logic signed [COORD_WIDTH-1:0] a_y,
   output logic signed [COORD_WIDTH-1:0] a_px,
   output logic signed [COORD_WIDTH-1:0] a_py,
   output logic signed [COORD_WIDTH-1:0] a_ox,
   output logic signed [COORD_WIDTH-1:0] a_oy,
   output logic signed [COORD_WIDTH-1:0] a_fx,
   output logic signed [COORD_WIDTH-1:0] a_fy,
   output logic signed [COORD_WIDTH-1:0] a_sx,
   output logic signed [COORD_WIDTH-1:0] a_sy
);

   logic [1:0] count_ff, count_in;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, first_x_in, first_y_in;
   logic signed [COORD_WIDTH-1:0] second_x_ff, second_y_ff, second_x_in, second_y_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   logic signed [COORD_WIDTH-1:0] older_x_ff, older_y_ff, older_x_in, older_y_in;
   logic signed [COORD_WIDTH-1:0] fx_sel, fy_sel, sx_sel, sy_sel;
   pac_ctrl_type ctrl_ff, ctrl_in;

   // First and second vertex as seen by this item (itself when it is that vertex)
   assign fx_sel = (count_ff == CNT_NONE) ? x : first_x_ff;
   assign fy_sel = (count_ff == CNT_NONE) ? y : first_y_ff;
   assign sx_sel = (count_ff == CNT_ONE) ? x : second_x_ff;
   assign sy_sel = (count_ff == CNT_ONE) ? y : second_y_ff;

   // History update; the closing vertex returns everything to the empty polygon
   always_comb begin
      count_in = count_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      second_x_in = second_x_ff;
      second_y_in = second_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      older_x_in = older_x_ff;
      older_y_in = older_y_ff;
      if (acc) begin
         if (last) begin
            count_in = CNT_NONE;
            first_x_in = '0;
            first_y_in = '0;
            second_x_in = '0;
            second_y_in = '0;
            prev_x_in = '0;
            prev_y_in = '0;
            older_x_in = '0;
            older_y_in = '0;
         end else begin
            count_in = (count_ff == CNT_MANY) ? CNT_MANY : count_ff + 2'd1;
            first_x_in = fx_sel;
            first_y_in = fy_sel;
            second_x_in = sx_sel;
            second_y_in = sy_sel;
            older_x_in = prev_x_ff;
            older_y_in = prev_y_ff;
            prev_x_in = x;
            prev_y_in = y;
         end
      end
   end

   always_comb begin
      ctrl_in.valid = acc;
      ctrl_in.last = last;
      ctrl_in.has_prev = (count_ff != CNT_NONE);
      ctrl_in.has_turn = (count_ff == CNT_MANY);
   end

   // History registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_NONE;
         first_x_ff <= '0;
         first_y_ff <= '0;
         second_x_ff <= '0;
         second_y_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         older_x_ff <= '0;
         older_y_ff <= '0;
      end else begin
         count_ff <= count_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         second_x_ff <= second_x_in;
         second_y_ff <= second_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         older_x_ff <= older_x_in;
         older_y_ff <= older_y_in;
      end
   end

   // Input stage: the vertex with its full neighborhood
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         a_x <= x;
         a_y <= y;
         a_px <= prev_x_ff;
         a_py <= prev_y_ff;
         a_ox <= older_x_ff;
         a_oy <= older_y_ff;
         a_fx <= fx_sel;
         a_fy <= fy_sel;
         a_sx <= sx_sel;
         a_sy <= sy_sel;
      end
   end

   assign a_ctrl = ctrl_ff;

endmodule

// File: rtl/pac_mult.sv
// Edge and turn products, then edge sum and turn signs, two register stages.
module pac_mult
   import pac_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  pac_ctrl_type                  a_ctrl,
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] a_px,
   input  logic signed [COORD_WIDTH-1:0] a_py,
   input  logic signed [COORD_WIDTH-1:0] a_ox,
   input  logic signed [COORD_WIDTH-1:0] a_oy,
   input  logic signed [COORD_WIDTH-1:0] a_fx,
   input  logic signed [COORD_WIDTH-1:0] a_fy,
   input  logic signed [COORD_WIDTH-1:0] a_sx,
   input  logic signed [COORD_WIDTH-1:0] a_sy,
   output pac_ctrl_type                  c_ctrl,
   output logic signed [SUM_W-1:0]       c_edge_sum,
   output logic                          c_pos,
   output logic                          c_neg
);

   localparam int D_W = COORD_WIDTH + 1;   // sums and differences
   localparam int P_W = 2 * D_W;           // products
   localparam int X_W = P_W + 1;           // cross products

   logic signed [D_W-1:0] x, y, px, py, ox, oy, fx, fy, sx, sy;
   pac_ctrl_type b_ctrl_ff, c_ctrl_ff;
   logic signed [P_W-1:0] e1_ff, e2_ff;
   logic signed [P_W-1:0] m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;
   logic signed [X_W-1:0] cr1, cr2, cr3;
   logic signed [SUM_W-1:0] ce1, ce2;
   logic en1, en23;
   logic pos_in, neg_in;
   logic signed [SUM_W-1:0] edge_sum_ff;
   logic pos_ff, neg_ff;

   assign x = D_W'(a_x);
   assign y = D_W'(a_y);
   assign px = D_W'(a_px);
   assign py = D_W'(a_py);
   assign ox = D_W'(a_ox);
   assign oy = D_W'(a_oy);
   assign fx = D_W'(a_fx);
   assign fy = D_W'(a_fy);
   assign sx = D_W'(a_sx);
   assign sy = D_W'(a_sy);

   // Product stage: edge from previous, closing edge, and three turns
   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff <= (px + x) * (py - y);
         e2_ff <= (x + fx) * (y - fy);
         // turn older -> previous -> current
         m1_ff <= (px - ox) * (y - py);
         m2_ff <= (py - oy) * (x - px);
         // turn previous -> current -> first
         m3_ff <= (x - px) * (fy - y);
         m4_ff <= (y - py) * (fx - x);
         // turn current -> first -> second
         m5_ff <= (fx - x) * (sy - fy);
         m6_ff <= (fy - y) * (sx - fx);
      end
   end

   // Combine stage: gate terms that do not exist for this vertex
   assign en1 = b_ctrl_ff.has_turn;
   assign en23 = b_ctrl_ff.has_turn & b_ctrl_ff.last;
   assign cr1 = X_W'(m1_ff) - X_W'(m2_ff);
   assign cr2 = X_W'(m3_ff) - X_W'(m4_ff);
   assign cr3 = X_W'(m5_ff) - X_W'(m6_ff);
   assign ce1 = b_ctrl_ff.has_prev ? SUM_W'(e1_ff) : '0;
   assign ce2 = b_ctrl_ff.last ? SUM_W'(e2_ff) : '0;

   always_comb begin
      pos_in = (en1 && cr1 > 0) || (en23 && (cr2 > 0 || cr3 > 0));
      neg_in = (en1 && cr1 < 0) || (en23 && (cr2 < 0 || cr3 < 0));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         edge_sum_ff <= ce1 + ce2;
         pos_ff <= pos_in;
         neg_ff <= neg_in;
      end
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
         c_ctrl_ff <= '0;
      end else if (adv) begin
         b_ctrl_ff <= a_ctrl;
         c_ctrl_ff <= b_ctrl_ff;
      end
   end

   assign c_ctrl = c_ctrl_ff;
   assign c_edge_sum = edge_sum_ff;
   assign c_pos = pos_ff;
   assign c_neg = neg_ff;

endmodule

// File: rtl/pac_accum.sv
// Shoelace accumulator, turn flags, magnitude with saturation and result register.
module pac_accum
   import pac_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  pac_ctrl_type            c_ctrl,
   input  logic signed [SUM_W-1:0] c_edge_sum,
   input  logic                    c_pos,
   input  logic                    c_neg,
   input  logic                    rsp_ready,
   output logic                    adv,
   output logic                    rsp_valid,
   output logic [AREA_W-1:0]       rsp_double_area,
   output logic                    rsp_is_concave
);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic seen_pos_ff, seen_neg_ff;
   logic seen_pos_in, seen_neg_in;
   logic fin_valid_ff;
   logic [SUM_W-1:0] fin_sum_ff;
   logic fin_concave_ff;
   logic [SUM_W-1:0] mag;
   logic [AREA_W-1:0] area;
   logic out_valid_ff;
   logic [AREA_W-1:0] out_area_ff;
   logic out_concave_ff;

   // Stall only while one result waits in each of the last two registers
   assign adv = !(fin_valid_ff && out_valid_ff && !rsp_ready);

   assign sum_in = sum_ff + c_edge_sum;
   assign seen_pos_in = seen_pos_ff | c_pos;
   assign seen_neg_in = seen_neg_ff | c_neg;

   // Accumulate; the closing vertex takes the total and clears the sums
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         seen_pos_ff <= 1'b0;
         seen_neg_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= c_ctrl.valid && c_ctrl.last;
         if (c_ctrl.valid) begin
            if (c_ctrl.last) begin
               sum_ff <= '0;
               seen_pos_ff <= 1'b0;
               seen_neg_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               seen_pos_ff <= seen_pos_in;
               seen_neg_ff <= seen_neg_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_ctrl.valid && c_ctrl.last) begin
         fin_sum_ff <= sum_in;
         fin_concave_ff <= c_ctrl.has_turn && seen_pos_in && seen_neg_in;
      end
   end

   // Absolute value, clipped to the result width
   assign mag = fin_sum_ff[SUM_W-1] ? (~fin_sum_ff + 1'b1) : fin_sum_ff;
   assign area = (|mag[SUM_W-1:AREA_W]) ? '1 : mag[AREA_W-1:0];

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (fin_valid_ff && (!out_valid_ff || rsp_ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff && (!out_valid_ff || rsp_ready)) begin
         out_area_ff <= area;
         out_concave_ff <= fin_concave_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_double_area = out_area_ff;
   assign rsp_is_concave = out_concave_ff;

endmodule
